@@ sv/bpa_pkg.sv @@
// bpa_pkg: shared types, codes and helpers for the bitmap page allocator
// no dependencies; imported by bpa_summary, bitmap_page_allocator and the bench

package bpa_pkg;

  localparam int PAGE_COUNT_DEF = 65536;
  localparam int ADDR_PAGES     = 1 << 16;   // pages reachable by a 16-bit page number
  localparam int WORD_BITS      = 64;
  localparam int WORD_IDX_W     = 10;        // 16-bit page number / 64 pages per word

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RESERVE = 2'd1,
    FUNC_FREE    = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_MODIFY,
    ST_RESP
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] page_number;
  } req_t;

  typedef struct packed {
    logic [15:0] result_page;
    logic        found;
    logic        page_free;
    logic        page_reserved;
  } rsp_t;

  // one map word: reserved marks and free marks of 64 pages
  typedef struct packed {
    logic [WORD_BITS-1:0] rsv;
    logic [WORD_BITS-1:0] fre;
  } map_word_t;

  typedef struct packed {
    logic                  wr;
    logic [WORD_IDX_W-1:0] word;
    logic                  nonempty;
  } sum_upd_t;

  typedef struct packed {
    logic                  hit;
    logic [WORD_IDX_W-1:0] word;
  } sum_hit_t;

  // lowest set bit of a 64-bit word, binary search in six steps
  function automatic logic [5:0] ffs64(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  idx;
    x   = v;
    idx = '0;
    if (x[31:0] == 32'd0) begin
      idx[5] = 1'b1;
      x      = x >> 32;
    end
    if (x[15:0] == 16'd0) begin
      idx[4] = 1'b1;
      x      = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      idx[3] = 1'b1;
      x      = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      idx[2] = 1'b1;
      x      = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      idx[1] = 1'b1;
      x      = x >> 2;
    end
    if (x[0] == 1'b0) begin
      idx[0] = 1'b1;
    end
    return idx;
  endfunction

endpackage

@@ sv/bpa_ram.sv @@
// bpa_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module bpa_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bpa_summary.sv @@
// bpa_summary: one bit per map word telling whether that word holds any free page
// depends on bpa_pkg; rows of 64 bits are scanned one per cycle by the top level

module bpa_summary #(
  parameter int WORD_COUNT = 1024,
  localparam int ROWS = (WORD_COUNT + 63) / 64,
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [RW-1:0]     row,
  input  bpa_pkg::sum_upd_t upd,
  output bpa_pkg::sum_hit_t hit
);

  import bpa_pkg::*;

  logic [WORD_BITS-1:0] bits [ROWS];
  logic [RW-1:0]        upd_row;
  logic [5:0]           upd_bit;
  logic [WORD_BITS-1:0] cur_row;

  assign upd_row = RW'(upd.word >> 6);
  assign upd_bit = upd.word[5:0];
  assign cur_row = bits[row];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        bits[i] <= '0;
      end
    end else if (upd.wr) begin
      bits[upd_row][upd_bit] <= upd.nonempty;
    end
  end

  always_comb begin
    hit.hit  = |cur_row;
    hit.word = WORD_IDX_W'({row, ffs64(cur_row)});
  end

endmodule

@@ sv/bitmap_page_allocator.sv @@
// bitmap_page_allocator: free and reserved page maps in one ram of 64-page words
// depends on bpa_pkg, bpa_ram, bpa_summary
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (bpa_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (bpa_pkg::rsp_t)
//
// in-range reserve, free, query: the read, modify and respond states follow the transfer
// allocate first scans the summary rows; a row covers 4096 pages, 16 rows at most
// pages beyond the maps and an allocate with nothing free skip the read and modify cycles
// after reset a clearing pass writes every map word, one per cycle;
// requests stall meanwhile
// one request in flight; the next is taken while the previous result waits in the output register

module bitmap_page_allocator #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bpa_pkg::rsp_t rsp
);

  import bpa_pkg::*;

  localparam int EFF_PAGES = (PAGE_COUNT < ADDR_PAGES) ? PAGE_COUNT : ADDR_PAGES;
  localparam int WORDS     = (EFF_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROWS      = (WORDS + 63) / 64;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MW        = $bits(map_word_t);

  state_t         state, state_next;
  req_t           cur;
  logic [WAW-1:0] word_addr;
  logic [WAW-1:0] clear_addr;
  logic [RW-1:0]  row;
  rsp_t           res;

  logic           in_range;
  logic           accept;
  logic           load;
  logic           last_row;

  logic           ram_we;
  logic [WAW-1:0] ram_waddr;
  logic [MW-1:0]  ram_wdata;
  logic [MW-1:0]  ram_rdata;
  map_word_t      rd;
  map_word_t      wr_word;
  logic [5:0]     bit_pos;
  logic [63:0]    mask;

  sum_upd_t       sum_upd;
  sum_hit_t       sum_hit;

  bpa_ram #(
    .WIDTH(MW),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(word_addr),
    .rdata(ram_rdata)
  );

  bpa_summary #(
    .WORD_COUNT(WORDS)
  ) u_summary (
    .clk(clk),
    .rst(rst),
    .row(row),
    .upd(sum_upd),
    .hit(sum_hit)
  );

  assign in_range = 32'(req.page_number) < 32'(EFF_PAGES);
  assign accept   = req_valid && !req_stall;
  assign last_row = row == RW'(ROWS - 1);
  assign rd       = map_word_t'(ram_rdata);

  // modify step: bit position and updated word
  always_comb begin
    bit_pos = (cur.func == FUNC_ALLOC) ? ffs64(rd.fre) : cur.page_number[5:0];
    mask    = 64'd1 << bit_pos;
    wr_word = rd;
    case (cur.func)
      FUNC_ALLOC: begin
        wr_word.fre = rd.fre & ~mask;
      end
      FUNC_RESERVE: begin
        wr_word.rsv = rd.rsv | mask;
        wr_word.fre = rd.fre & ~mask;
      end
      FUNC_FREE: begin
        wr_word.fre = rd.fre | mask;
        wr_word.rsv = rd.rsv & ~mask;
      end
      default: begin
        wr_word = rd;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == WAW'(WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.func == FUNC_ALLOC) state_next = ST_SCAN;
          else if (in_range)          state_next = ST_READ;
          else                        state_next = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (sum_hit.hit)   state_next = ST_READ;
        else if (last_row) state_next = ST_RESP;
      end
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_RESP;
      ST_RESP: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_stall        = 1'b1;
    ram_we           = 1'b0;
    ram_waddr        = word_addr;
    ram_wdata        = MW'(wr_word);
    sum_upd.wr       = 1'b0;
    sum_upd.word     = WORD_IDX_W'(word_addr);
    sum_upd.nonempty = |wr_word.fre;
    load             = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_MODIFY: begin
        ram_we     = 1'b1;
        sum_upd.wr = 1'b1;
      end
      ST_RESP: begin
        load = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clear_addr <= clear_addr + WAW'(1);
      if (load)              rsp_valid  <= 1'b1;
      else if (!rsp_stall)   rsp_valid  <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= req;
      word_addr <= WAW'(req.page_number >> 6);
      row       <= '0;
      // out of range page: ignored, marks read as zero
      res       <= '{result_page: req.page_number, found: 1'b1,
                     page_free: 1'b0, page_reserved: 1'b0};
    end
    if (state == ST_SCAN) begin
      if (sum_hit.hit) begin
        word_addr <= WAW'(sum_hit.word);
      end else if (last_row) begin
        res <= '0;  // no free page
      end else begin
        row <= row + RW'(1);
      end
    end
    if (state == ST_MODIFY) begin
      res.result_page   <= (cur.func == FUNC_ALLOC) ? 16'({word_addr, bit_pos})
                                                   : cur.page_number;
      res.found         <= 1'b1;
      res.page_free     <= wr_word.fre[bit_pos];
      res.page_reserved <= wr_word.rsv[bit_pos];
    end
    if (load) begin
      rsp <= res;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for bitmap_page_allocator, request driver and result checker
// depends on bpa_pkg and bitmap_page_allocator; keeps its own copy of the free and reserved maps

module tb_top;
  import bpa_pkg::*;

  localparam int PAGES     = PAGE_COUNT_DEF;
  localparam int MAP_WORDS = ADDR_PAGES / WORD_BITS;

  typedef struct packed {
    req_t r;
    bit   drain;   // hold this request until every result is back
  } pending_req_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pending_req_t pending[$];
  rsp_t         expected_rsp[$];
  int           n_accepted = 0;
  int           n_results  = 0;
  int           n_mismatch = 0;
  int           send_gap   = 0;
  int           stall_left = 0;
  bit           calm_tx    = 0;
  bit           calm_rx    = 0;

  // shadow page maps, one bit per page
  bit [WORD_BITS-1:0] free_words [MAP_WORDS];
  bit [WORD_BITS-1:0] rsv_words  [MAP_WORDS];

  bitmap_page_allocator #(.PAGE_COUNT(PAGES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // updates the shadow maps and returns the result the block owes for this request
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   w;
    int   b;
    int   pg;
    bit   hit;
    o               = '0;
    o.found         = 1'b1;
    o.result_page   = r.page_number;
    pg              = r.page_number;
    hit             = 1'b0;
    if (r.func == FUNC_ALLOC) begin
      for (w = 0; w < MAP_WORDS && !hit; w++) begin
        if (free_words[w] != '0) begin
          b = 0;
          while (!free_words[w][b]) b++;
          pg  = w * WORD_BITS + b;
          hit = 1'b1;
        end
      end
      if (hit && pg < PAGES) begin
        free_words[pg >> 6][pg & 63] = 1'b0;
        o.result_page   = pg[15:0];
        o.page_reserved = rsv_words[pg >> 6][pg & 63];
      end else begin
        o.result_page = '0;
        o.found       = 1'b0;
      end
    end else if (pg < PAGES) begin
      case (r.func)
        FUNC_RESERVE: begin
          rsv_words[pg >> 6][pg & 63]  = 1'b1;
          free_words[pg >> 6][pg & 63] = 1'b0;
        end
        FUNC_FREE: begin
          free_words[pg >> 6][pg & 63] = 1'b1;
          rsv_words[pg >> 6][pg & 63]  = 1'b0;
        end
        default: ;
      endcase
      o.page_free     = free_words[pg >> 6][pg & 63];
      o.page_reserved = rsv_words[pg >> 6][pg & 63];
    end
    return o;
  endfunction

  // mostly short pauses, a few long ones
  function automatic int pause_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
  endfunction

  task automatic queue_request(func_t f, int page, bit drain);
    pending_req_t p;
    p.r.func        = f;
    p.r.page_number = page[15:0];
    p.drain         = drain;
    pending.push_back(p);
  endtask

  // request driver
  always @(posedge clk) begin : drive_req
    int g;
    int acc_total;
    bit took;
    bit hold;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      took      = req_valid && !req_stall;
      hold      = req_valid && req_stall;
      g         = send_gap;
      acc_total = n_accepted;
      if (took) begin
        expected_rsp.push_back(apply_request(req));
        acc_total = n_accepted + 1;
        n_accepted <= acc_total;
        if ($urandom_range(0, 99) < 3) calm_tx = !calm_tx;
        g = (calm_tx || $urandom_range(0, 1) == 0) ? 0 : pause_len();
      end
      if (!hold) begin
        if (g != 0) begin
          g = g - 1;
          req_valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && n_results != acc_total)) begin
          req       <= pending[0].r;
          req_valid <= 1'b1;
          void'(pending.pop_front());
        end else begin
          req_valid <= 1'b0;
        end
      end
      send_gap <= g;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin : check_rsp
    int   g;
    rsp_t want;
    bit   bad;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_results <= n_results + 1;
        if (expected_rsp.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result transfer: page %0d found %0b free %0b reserved %0b",
                     rsp.result_page, rsp.found, rsp.page_free, rsp.page_reserved);
        end else begin
          want = expected_rsp.pop_front();
          bad  = (rsp.result_page !== want.result_page) || (rsp.found !== want.found) ||
                 (rsp.page_free !== want.page_free) ||
                 (rsp.page_reserved !== want.page_reserved);
          if (bad) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d mismatch: expected page %0d found %0b free %0b rsv %0b, %s",
                       n_results, want.result_page, want.found, want.page_free,
                       want.page_reserved,
                       $sformatf("got page %0d found %0b free %0b rsv %0b",
                                 rsp.result_page, rsp.found, rsp.page_free,
                                 rsp.page_reserved));
          end
        end
      end
      g = stall_left;
      if ($urandom_range(0, 99) < 2) calm_rx = !calm_rx;
      if (g != 0) begin
        g = g - 1;
        rsp_stall <= 1'b1;
      end else if (!calm_rx && $urandom_range(0, 3) == 0) begin
        g = pause_len() - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
      stall_left <= g;
    end
  end

  initial begin : stimulus
    int    i;
    int    sel;
    int    page;
    func_t f;

    // directed: empty allocate, map edges, word boundaries, mark interplay
    queue_request(FUNC_ALLOC,   0,      1'b0);   // nothing free yet
    queue_request(FUNC_QUERY,   0,      1'b0);
    queue_request(FUNC_QUERY,   65535,  1'b0);
    queue_request(FUNC_RESERVE, 65535,  1'b0);
    queue_request(FUNC_FREE,    65535,  1'b0);
    queue_request(FUNC_ALLOC,   12345,  1'b0);   // scan reaches the last word
    queue_request(FUNC_ALLOC,   0,      1'b0);
    queue_request(FUNC_FREE,    0,      1'b0);
    queue_request(FUNC_FREE,    1,      1'b0);
    queue_request(FUNC_RESERVE, 1,      1'b0);   // reserve takes away the free mark
    queue_request(FUNC_QUERY,   1,      1'b0);
    queue_request(FUNC_ALLOC,   65535,  1'b0);
    queue_request(FUNC_FREE,    16'h5555, 1'b0);
    queue_request(FUNC_FREE,    16'hAAAA, 1'b0);
    queue_request(FUNC_QUERY,   16'hAAAA, 1'b0);
    queue_request(FUNC_ALLOC,   16'hFFFF, 1'b1);
    queue_request(FUNC_ALLOC,   0,      1'b0);
    queue_request(FUNC_RESERVE, 16'hAAAA, 1'b0);
    queue_request(FUNC_FREE,    64,     1'b0);
    queue_request(FUNC_FREE,    63,     1'b0);
    queue_request(FUNC_ALLOC,   0,      1'b0);
    queue_request(FUNC_ALLOC,   0,      1'b0);
    queue_request(FUNC_QUERY,   16'h8000, 1'b0);

    // random: mostly a small page window so allocate and free interact
    for (i = 0; i < 1030; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)      f = FUNC_ALLOC;
      else if (sel < 45) f = FUNC_RESERVE;
      else if (sel < 80) f = FUNC_FREE;
      else               f = FUNC_QUERY;
      sel = $urandom_range(0, 99);
      if (sel < 75)      page = $urandom_range(0, 255);
      else if (sel < 85) page = $urandom_range(65280, 65535);
      else               page = $urandom_range(0, 65535);
      queue_request(f, page, (i % 150) == 149);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || n_results != n_accepted) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_mismatch == 0 && expected_rsp.size() == 0) begin
      $display("bitmap_page_allocator regression: pass");
    end else begin
      $display("bitmap_page_allocator regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("bitmap_page_allocator regression: fail");
    $finish;
  end

endmodule
